FILE: design/hsd_pkg.sv
`default_nettype none

package hsd_pkg;

    // stream format
    localparam int BYTE_W   = 8;   // code bits per input word
    localparam int KEY_W    = 8;   // key bits carried by a leaf
    localparam int HDR_W    = 3;   // header: valid bits in the final word
    localparam int HCNT_W   = 2;
    localparam int KCNT_W   = 4;
    localparam int BCNT_W   = $clog2(BYTE_W + 1);

    localparam logic [HCNT_W-1:0] HDR_LAST = HCNT_W'(HDR_W - 1);
    localparam logic [KCNT_W-1:0] KEY_BITS = KCNT_W'(KEY_W);

    // default sizes of the node store and the parent stack
    localparam int MAX_NODES_DEF   = 511;
    localparam int STACK_DEPTH_DEF = 256;

    // result status codes
    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_TREE,
        PH_CODE,
        PH_HALT
    } hsd_phase_t;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_BITS,
        ENG_FINISH
    } hsd_eng_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              final_byte;
    } hsd_in_t;

    typedef struct packed {
        logic [KEY_W-1:0] symbol;
        logic             status;
        logic             run_last;
    } hsd_out_t;

endpackage

`default_nettype wire

FILE: design/huffman_stream_decoder_unit.sv
// huffman stream decoder with the code tree carried in the stream itself
//
// s_ channel: one compressed word per handshake (s_data.data_byte, msb first)
// and s_data.final_byte marking the last word of a stream. m_ channel: one
// result per handshake (symbol, status, run_last); run_last flags the last
// result caused by an input word, and a word may cause none.
// a word is worked one bit per cycle from a shift register unless stalled;
// in the code phase each used bit costs one node store read, so the tree
// walk paces the block. a word is accepted in the idle state, its bits are
// worked, then the last node fetch is resolved and the final result is
// released; a new word is taken only after that. every leaf built in the
// tree phase adds a link step that ties it to its parent.
// the result register and a one-deep hold stage part the two sides: the block
// keeps decoding while a result waits, and only stops when both are full.
// reset (aresetn low, synchronous) clears all control state; node store and
// parent stack are not cleared, they are written before they are read.
// after a final word the block returns to the header phase for a new stream.
// overflow of node store or stack gives one error result (status set) and
// the rest of the stream is ignored up to its final word.
`default_nettype none

module huffman_stream_decoder_unit
    import hsd_pkg::*;
#(
    parameter int MAX_NODES   = MAX_NODES_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire hsd_in_t  s_data,
    input  wire logic     s_valid,
    output logic          s_ready,
    output hsd_out_t      m_data,
    output logic          m_valid,
    input  wire logic     m_ready
);

    localparam int IDX_W  = $clog2(MAX_NODES);
    localparam int NCNT_W = $clog2(MAX_NODES + 1);
    localparam int FLD_W  = (IDX_W > KEY_W) ? IDX_W : KEY_W;
    localparam int LO_W   = FLD_W + 1;          // leaf flag, left child or key
    localparam int SIDX_W = $clog2(STACK_DEPTH);
    localparam int SCNT_W = $clog2(STACK_DEPTH + 1);
    localparam int STK_W  = IDX_W + 1;          // right-pending flag, parent

    // node store split in two so either child field is written on its own
    logic [LO_W-1:0]  lo_mem [MAX_NODES];
    logic [IDX_W-1:0] rt_mem [MAX_NODES];
    // parent stack below the top entry, which lives in registers
    logic [STK_W-1:0] stk_mem [STACK_DEPTH];

    // engine and stream state
    hsd_eng_t           state_reg, state_next;
    hsd_phase_t         phase_reg, phase_next;
    logic [HCNT_W-1:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [HDR_W-1:0]   fvb_reg, fvb_next;
    logic [KEY_W-1:0]   key_shift_reg, key_shift_next;
    logic [KCNT_W-1:0]  key_cnt_reg, key_cnt_next;
    logic [NCNT_W-1:0]  nf_reg, nf_next;
    logic [SCNT_W-1:0]  stk_cnt_reg, stk_cnt_next;
    logic [IDX_W-1:0]   top_idx_reg, top_idx_next;
    logic               top_rp_reg, top_rp_next;
    logic               link_pend_reg, link_pend_next;
    logic [IDX_W-1:0]   link_idx_reg, link_idx_next;
    logic               fetch_pend_reg, fetch_pend_next;
    logic [LO_W-1:0]    cur_lo_reg, cur_lo_next;
    logic [IDX_W-1:0]   cur_rt_reg, cur_rt_next;
    logic [LO_W-1:0]    root_lo_reg, root_lo_next;
    logic [IDX_W-1:0]   root_rt_reg, root_rt_next;
    logic [BYTE_W-1:0]  byte_sr_reg, byte_sr_next;
    logic               fin_reg, fin_next;
    logic [BCNT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic               hold_valid_reg, hold_valid_next;
    hsd_out_t           hold_reg, hold_next;
    logic               m_valid_reg, m_valid_next;
    hsd_out_t           m_data_reg, m_data_next;

    // registered memory read data
    logic [LO_W-1:0]    rd_lo_reg;
    logic [IDX_W-1:0]   rd_rt_reg;
    logic [STK_W-1:0]   stk_rd_reg;

    // memory control
    logic               lo_we, rt_we, stk_we, node_re;
    logic [IDX_W-1:0]   lo_waddr, rt_waddr, node_raddr;
    logic [LO_W-1:0]    lo_wdata;
    logic [IDX_W-1:0]   rt_wdata;
    logic [SIDX_W-1:0]  stk_waddr, stk_raddr;
    logic [STK_W-1:0]   stk_wdata;

    logic               stall, bits_done;

    assign stk_raddr = SIDX_W'(stk_cnt_reg - SCNT_W'(2));

    // ------------------------------------------------------------------
    // engine sequencing
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ENG_IDLE: begin
                if (s_valid) begin
                    state_next = ENG_BITS;
                end
            end
            ENG_BITS: begin
                if (!stall && bits_done) begin
                    state_next = ENG_FINISH;
                end
            end
            ENG_FINISH: begin
                if (!stall && !fetch_pend_reg) begin
                    state_next = ENG_IDLE;
                end
            end
            default: state_next = ENG_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath: unless stalled, one code bit, one link, one resolve or one flush step per cycle
    // ------------------------------------------------------------------
    always_comb begin
        logic             cur_bit;
        logic             out_free;
        logic             res_hit;
        logic [LO_W-1:0]  e_lo;
        logic [IDX_W-1:0] e_rt;
        logic             bit_step, link_step, resolve_step, flush_step;
        logic             produce;
        hsd_out_t         prod_res;
        logic             nf_full, stk_full;
        logic             tree_err;
        logic             use_bit;
        logic             enter_code;
        logic [KEY_W-1:0] key_full;
        logic             out_load;
        hsd_out_t         out_word;

        cur_bit  = byte_sr_reg[BYTE_W-1];
        out_free = !m_valid_reg || m_ready;
        nf_full  = (nf_reg == NCNT_W'(MAX_NODES));
        stk_full = (stk_cnt_reg == SCNT_W'(STACK_DEPTH));
        key_full = {key_shift_reg[KEY_W-2:0], cur_bit};

        // the node fetched for the previous bit: a leaf emits and restarts at the root
        res_hit = fetch_pend_reg && rd_lo_reg[LO_W-1];
        if (fetch_pend_reg) begin
            e_lo = res_hit ? root_lo_reg : rd_lo_reg;
            e_rt = res_hit ? root_rt_reg : rd_rt_reg;
        end else begin
            e_lo = cur_lo_reg;
            e_rt = cur_rt_reg;
        end

        bit_step     = (state_reg == ENG_BITS) && !link_pend_reg;
        link_step    = (state_reg == ENG_BITS) && link_pend_reg;
        resolve_step = (state_reg == ENG_FINISH) && fetch_pend_reg;
        flush_step   = (state_reg == ENG_FINISH) && !fetch_pend_reg;

        if (key_cnt_reg != '0) begin
            tree_err = (key_cnt_reg == KCNT_W'(1)) && nf_full;
        end else begin
            tree_err = !cur_bit && (nf_full || stk_full);
        end

        produce  = 1'b0;
        prod_res = '{symbol: '0, status: ST_OK, run_last: 1'b0};
        if (bit_step && phase_reg == PH_TREE && tree_err) begin
            produce  = 1'b1;
            prod_res = '{symbol: '0, status: ST_ERR, run_last: 1'b0};
        end else if ((bit_step && phase_reg == PH_CODE) || resolve_step) begin
            produce  = res_hit;
            prod_res = '{symbol: rd_lo_reg[KEY_W-1:0], status: ST_OK, run_last: 1'b0};
        end

        if (flush_step) begin
            stall = hold_valid_reg && !out_free;
        end else begin
            stall = produce && hold_valid_reg && !out_free;
        end

        // defaults
        phase_next      = phase_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        fvb_next        = fvb_reg;
        key_shift_next  = key_shift_reg;
        key_cnt_next    = key_cnt_reg;
        nf_next         = nf_reg;
        stk_cnt_next    = stk_cnt_reg;
        top_idx_next    = top_idx_reg;
        top_rp_next     = top_rp_reg;
        link_pend_next  = link_pend_reg;
        link_idx_next   = link_idx_reg;
        fetch_pend_next = fetch_pend_reg;
        cur_lo_next     = cur_lo_reg;
        cur_rt_next     = cur_rt_reg;
        byte_sr_next    = byte_sr_reg;
        fin_next        = fin_reg;
        bit_cnt_next    = bit_cnt_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        lo_we           = 1'b0;
        lo_waddr        = '0;
        lo_wdata        = '0;
        rt_we           = 1'b0;
        rt_waddr        = '0;
        rt_wdata        = '0;
        stk_we          = 1'b0;
        stk_waddr       = SIDX_W'(stk_cnt_reg - SCNT_W'(1));
        stk_wdata       = {1'b1, top_idx_reg};
        node_re         = 1'b0;
        node_raddr      = '0;
        use_bit         = 1'b0;
        enter_code      = 1'b0;
        out_load        = 1'b0;
        out_word        = hold_reg;

        if (state_reg == ENG_IDLE) begin
            if (s_valid) begin
                byte_sr_next = s_data.data_byte;
                fin_next     = s_data.final_byte;
                bit_cnt_next = '0;
            end
        end else if (!stall) begin
            if (bit_step) begin
                byte_sr_next = byte_sr_reg << 1;
                bit_cnt_next = bit_cnt_reg + BCNT_W'(1);
                unique case (phase_reg)
                    PH_HEADER: begin
                        fvb_next = {fvb_reg[HDR_W-2:0], cur_bit};
                        if (hdr_cnt_reg == HDR_LAST) begin
                            hdr_cnt_next = '0;
                            phase_next   = PH_TREE;
                        end else begin
                            hdr_cnt_next = hdr_cnt_reg + HCNT_W'(1);
                        end
                    end
                    PH_TREE: begin
                        if (tree_err) begin
                            phase_next = PH_HALT;
                            if (key_cnt_reg != '0) begin
                                key_shift_next = key_full;
                                key_cnt_next   = '0;
                            end
                        end else if (key_cnt_reg != '0) begin
                            key_shift_next = key_full;
                            key_cnt_next   = key_cnt_reg - KCNT_W'(1);
                            if (key_cnt_reg == KCNT_W'(1)) begin
                                // leaf complete: write it now, link it next cycle
                                lo_we          = 1'b1;
                                lo_waddr       = nf_reg[IDX_W-1:0];
                                lo_wdata       = {1'b1, FLD_W'(key_full)};
                                link_idx_next  = nf_reg[IDX_W-1:0];
                                nf_next        = nf_reg + NCNT_W'(1);
                                link_pend_next = 1'b1;
                            end
                        end else if (cur_bit) begin
                            key_cnt_next   = KEY_BITS;
                            key_shift_next = '0;
                        end else begin
                            // branch: link to parent, then becomes the new top
                            nf_next      = nf_reg + NCNT_W'(1);
                            top_idx_next = nf_reg[IDX_W-1:0];
                            top_rp_next  = 1'b0;
                            if (stk_cnt_reg == '0) begin
                                stk_cnt_next = SCNT_W'(1);
                            end else if (!top_rp_reg) begin
                                lo_we        = 1'b1;
                                lo_waddr     = top_idx_reg;
                                lo_wdata     = {1'b0, FLD_W'(nf_reg[IDX_W-1:0])};
                                stk_we       = 1'b1;
                                stk_cnt_next = stk_cnt_reg + SCNT_W'(1);
                            end else begin
                                rt_we    = 1'b1;
                                rt_waddr = top_idx_reg;
                                rt_wdata = nf_reg[IDX_W-1:0];
                            end
                        end
                    end
                    PH_CODE: begin
                        use_bit = !(fin_reg && (bit_cnt_reg[HDR_W-1:0] >= fvb_reg));
                        if (use_bit && !e_lo[LO_W-1]) begin
                            node_re         = 1'b1;
                            node_raddr      = cur_bit ? e_rt : e_lo[IDX_W-1:0];
                            fetch_pend_next = 1'b1;
                        end else begin
                            cur_lo_next     = e_lo;
                            cur_rt_next     = e_rt;
                            fetch_pend_next = 1'b0;
                        end
                    end
                    PH_HALT: begin
                    end
                    default: begin
                    end
                endcase
            end else if (link_step) begin
                link_pend_next = 1'b0;
                if (stk_cnt_reg != '0) begin
                    if (!top_rp_reg) begin
                        lo_we       = 1'b1;
                        lo_waddr    = top_idx_reg;
                        lo_wdata    = {1'b0, FLD_W'(link_idx_reg)};
                        top_rp_next = 1'b1;
                    end else begin
                        rt_we        = 1'b1;
                        rt_waddr     = top_idx_reg;
                        rt_wdata     = link_idx_reg;
                        top_idx_next = stk_rd_reg[IDX_W-1:0];
                        top_rp_next  = stk_rd_reg[IDX_W];
                        stk_cnt_next = stk_cnt_reg - SCNT_W'(1);
                    end
                end
                if (stk_cnt_next == '0) begin
                    phase_next      = PH_CODE;
                    fetch_pend_next = 1'b0;
                    enter_code      = 1'b1;
                end
            end else if (resolve_step) begin
                cur_lo_next     = e_lo;
                cur_rt_next     = e_rt;
                fetch_pend_next = 1'b0;
            end else if (flush_step) begin
                if (hold_valid_reg) begin
                    out_load          = 1'b1;
                    out_word          = hold_reg;
                    out_word.run_last = 1'b1;
                    hold_valid_next   = 1'b0;
                end
                if (fin_reg) begin
                    // stream over: back to the header phase
                    phase_next      = PH_HEADER;
                    hdr_cnt_next    = '0;
                    fvb_next        = '0;
                    key_shift_next  = '0;
                    key_cnt_next    = '0;
                    nf_next         = '0;
                    stk_cnt_next    = '0;
                    fetch_pend_next = 1'b0;
                    link_pend_next  = 1'b0;
                end
            end

            if (produce) begin
                if (hold_valid_reg) begin
                    out_load = 1'b1;
                    out_word = hold_reg;
                end
                hold_next       = prod_res;
                hold_valid_next = 1'b1;
            end
        end

        // mirror of the root entry, the restart point of every code walk
        root_lo_next = (lo_we && lo_waddr == '0) ? lo_wdata : root_lo_reg;
        root_rt_next = (rt_we && rt_waddr == '0) ? rt_wdata : root_rt_reg;
        if (enter_code) begin
            cur_lo_next = root_lo_next;
            cur_rt_next = root_rt_next;
        end

        bits_done = (bit_cnt_next == BCNT_W'(BYTE_W)) && !link_pend_next;

        m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        m_data_next  = out_load ? out_word : m_data_reg;
    end

    // ------------------------------------------------------------------
    // outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_ready = (state_reg == ENG_IDLE);
        m_valid = m_valid_reg;
        m_data  = m_data_reg;
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ENG_IDLE;
            phase_reg      <= PH_HEADER;
            hdr_cnt_reg    <= '0;
            fvb_reg        <= '0;
            key_shift_reg  <= '0;
            key_cnt_reg    <= '0;
            nf_reg         <= '0;
            stk_cnt_reg    <= '0;
            link_pend_reg  <= 1'b0;
            fetch_pend_reg <= 1'b0;
            bit_cnt_reg    <= '0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            hdr_cnt_reg    <= hdr_cnt_next;
            fvb_reg        <= fvb_next;
            key_shift_reg  <= key_shift_next;
            key_cnt_reg    <= key_cnt_next;
            nf_reg         <= nf_next;
            stk_cnt_reg    <= stk_cnt_next;
            link_pend_reg  <= link_pend_next;
            fetch_pend_reg <= fetch_pend_next;
            bit_cnt_reg    <= bit_cnt_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_idx_reg  <= top_idx_next;
        top_rp_reg   <= top_rp_next;
        link_idx_reg <= link_idx_next;
        cur_lo_reg   <= cur_lo_next;
        cur_rt_reg   <= cur_rt_next;
        root_lo_reg  <= root_lo_next;
        root_rt_reg  <= root_rt_next;
        byte_sr_reg  <= byte_sr_next;
        fin_reg      <= fin_next;
        hold_reg     <= hold_next;
        m_data_reg   <= m_data_next;
    end

    // node store
    always_ff @(posedge aclk) begin
        if (lo_we) begin
            lo_mem[lo_waddr] <= lo_wdata;
        end
        if (rt_we) begin
            rt_mem[rt_waddr] <= rt_wdata;
        end
        if (node_re) begin
            rd_lo_reg <= lo_mem[node_raddr];
            rd_rt_reg <= rt_mem[node_raddr];
        end
    end

    // parent stack, read port parked on the entry below the top
    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_rd_reg <= stk_mem[stk_raddr];
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stk_cnt_reg <= SCNT_W'(STACK_DEPTH))
        else $error("parent stack count beyond depth");

    a_node_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        nf_reg <= NCNT_W'(MAX_NODES))
        else $error("node allocation beyond store size");

    a_fetch_in_code: assert property (@(posedge aclk) disable iff (!aresetn)
        fetch_pend_reg |-> (phase_reg == PH_CODE))
        else $error("node fetch pending outside code phase");

    a_link_in_tree: assert property (@(posedge aclk) disable iff (!aresetn)
        link_pend_reg |-> (phase_reg == PH_TREE))
        else $error("leaf link pending outside tree phase");

    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ENG_IDLE) |-> (!hold_valid_reg && !fetch_pend_reg && !link_pend_reg))
        else $error("engine idle with work outstanding");

    a_finish_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ENG_FINISH && !fetch_pend_reg && (!m_valid_reg || m_ready))
        |=> (state_reg == ENG_IDLE))
        else $error("finish step did not release the engine");

endmodule

`default_nettype wire
